>>> rtl/core/rchw_pkg.sv
package rchw_pkg;

  localparam int TimeW  = 32;
  localparam int NumCnt = 7;

  localparam int C_SENT     = 0;
  localparam int C_OK       = 1;
  localparam int C_FAILED   = 2;
  localparam int C_TIMEOUTS = 3;
  localparam int C_TRIES    = 4;
  localparam int C_DONE     = 5;
  localparam int C_SUPPRESS = 6;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_EVENT = 2'd1,
    REQ_DONE  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PROBE   = 3'd1,
    PH_OFF     = 3'd2,
    PH_WAIT_ON = 3'd3,
    PH_ON      = 3'd4,
    PH_FAILED  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_PROBE     = 3'd1,
    ACT_POWER_OFF = 3'd2,
    ACT_POWER_ON  = 3'd3,
    ACT_REBOOT    = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    REG_SUPPRESS_MAX = 3'd0,
    REG_QUIET        = 3'd1,
    REG_NO_HANDLE    = 3'd2,
    REG_PROBE_TO     = 3'd3,
    REG_OFF_TO       = 3'd4,
    REG_ON_DELAY     = 3'd5,
    REG_ON_TO        = 3'd6
  } reg_e;

  localparam logic [TimeW-1:0] RstSuppressMax = 32'd30000;
  localparam logic [TimeW-1:0] RstQuiet       = 32'd2000;
  localparam logic [TimeW-1:0] RstNoHandle    = 32'd3000;
  localparam logic [TimeW-1:0] RstProbeTo     = 32'd1000;
  localparam logic [TimeW-1:0] RstOffTo       = 32'd2000;
  localparam logic [TimeW-1:0] RstOnDelay     = 32'd500;
  localparam logic [TimeW-1:0] RstOnTo        = 32'd5000;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [TimeW-1:0] now_ms;
    logic [7:0]       probe_status;
    logic             ctrl_working;
    logic             claimed_link;
    logic             security_active;
    logic             handle_available;
    logic             hci_is_off;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [2:0]       phase_now;
    logic [TimeW-1:0] count_probes_sent;
    logic [TimeW-1:0] count_probes_ok;
    logic [TimeW-1:0] count_probes_failed;
    logic [TimeW-1:0] count_probe_timeouts;
    logic [TimeW-1:0] count_recovery_tries;
    logic [TimeW-1:0] count_recovery_done;
    logic [TimeW-1:0] count_suppressions;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0] security_suppress_max_ms;
    logic [TimeW-1:0] quiet_before_probe_ms;
    logic [TimeW-1:0] no_handle_grace_ms;
    logic [TimeW-1:0] probe_timeout_ms;
    logic [TimeW-1:0] power_off_timeout_ms;
    logic [TimeW-1:0] power_on_delay_ms;
    logic [TimeW-1:0] power_on_timeout_ms;
  } cfg_t;

  typedef struct packed {
    phase_e                       phase;
    logic [TimeW-1:0]             phase_start;
    logic [TimeW-1:0]             last_event;
    logic [TimeW-1:0]             event_seq;
    logic [TimeW-1:0]             probe_snap;
    logic [TimeW-1:0]             sup_start;
    logic [TimeW-1:0]             nh_start;
    logic                         nh_armed;
    logic                         sup_armed;
    logic                         probe_nak;
    logic                         reboot_req;
    logic [NumCnt-1:0][TimeW-1:0] cnt;
  } state_t;

endpackage

>>> rtl/core/rchw_step.sv
module rchw_step
  import rchw_pkg::*;
(
  input  state_t   st,
  input  cfg_t     cfg,
  input  in_item_t item,
  output state_t   st_nxt,
  output action_e  action
);

  function automatic logic passed(input logic [TimeW-1:0] now,
                                  input logic [TimeW-1:0] since,
                                  input logic [TimeW-1:0] span);
    logic [TimeW-1:0] diff;
    diff = now - since;
    return diff >= span;
  endfunction

  logic [TimeW-1:0]  now;
  logic [TimeW-1:0]  phase_span;
  logic              phase_elapsed;
  logic              sup_elapsed;
  logic              quiet_elapsed;
  logic              nh_elapsed;
  logic [NumCnt-1:0] inc;
  logic              do_off;
  logic              do_fail;
  logic              blocked;

  assign now = item.now_ms;

  always_comb begin
    case (st.phase)
      PH_PROBE:   phase_span = cfg.probe_timeout_ms;
      PH_OFF:     phase_span = cfg.power_off_timeout_ms;
      PH_WAIT_ON: phase_span = cfg.power_on_delay_ms;
      PH_ON:      phase_span = cfg.power_on_timeout_ms;
      default:    phase_span = cfg.probe_timeout_ms;
    endcase
  end

  assign phase_elapsed = passed(now, st.phase_start, phase_span);
  assign sup_elapsed   = passed(now, st.sup_armed ? st.sup_start : now,
                                cfg.security_suppress_max_ms);
  assign quiet_elapsed = passed(now, st.last_event, cfg.quiet_before_probe_ms);
  assign nh_elapsed    = passed(now, st.nh_start, cfg.no_handle_grace_ms);

  always_comb begin
    st_nxt  = st;
    action  = ACT_NONE;
    inc     = '0;
    do_off  = 1'b0;
    do_fail = 1'b0;
    blocked = 1'b0;

    case (item.req_type)
      REQ_TICK: begin
        case (st.phase)
          PH_IDLE: begin
            if (!item.ctrl_working || !item.claimed_link) begin
              st_nxt.nh_armed  = 1'b0;
              st_nxt.sup_armed = 1'b0;
            end else begin
              if (item.security_active) begin
                if (!st.sup_armed) begin
                  st_nxt.sup_armed = 1'b1;
                  st_nxt.sup_start = now;
                  inc[C_SUPPRESS]  = 1'b1;
                end
                if (!sup_elapsed) begin
                  st_nxt.nh_armed = 1'b0;
                  blocked         = 1'b1;
                end
              end else begin
                st_nxt.sup_armed = 1'b0;
              end
              if (!blocked) begin
                if (!quiet_elapsed) begin
                  st_nxt.nh_armed = 1'b0;
                end else if (!item.handle_available) begin
                  if (!st.nh_armed) begin
                    st_nxt.nh_armed = 1'b1;
                    st_nxt.nh_start = now;
                  end else if (nh_elapsed) begin
                    do_off = 1'b1;
                  end
                end else begin
                  st_nxt.nh_armed    = 1'b0;
                  st_nxt.phase       = PH_PROBE;
                  st_nxt.phase_start = now;
                  st_nxt.probe_snap  = st.event_seq;
                  inc[C_SENT]        = 1'b1;
                  action             = ACT_PROBE;
                end
              end
            end
          end
          PH_PROBE: begin
            if (st.probe_nak) begin
              do_off = 1'b1;
            end else if (st.event_seq != st.probe_snap) begin
              inc[C_OK]          = 1'b1;
              st_nxt.phase       = PH_IDLE;
              st_nxt.phase_start = now;
            end else if (phase_elapsed) begin
              inc[C_TIMEOUTS] = 1'b1;
              do_off          = 1'b1;
            end
          end
          PH_OFF: begin
            if (item.hci_is_off) begin
              st_nxt.phase       = PH_WAIT_ON;
              st_nxt.phase_start = now;
            end else if (phase_elapsed) begin
              do_fail = 1'b1;
            end
          end
          PH_WAIT_ON: begin
            if (phase_elapsed) begin
              st_nxt.phase       = PH_ON;
              st_nxt.phase_start = now;
              action             = ACT_POWER_ON;
            end
          end
          PH_ON: begin
            if (item.ctrl_working) begin
              st_nxt.phase       = PH_IDLE;
              st_nxt.phase_start = now;
              st_nxt.last_event  = now;
              inc[C_DONE]        = 1'b1;
            end else if (phase_elapsed) begin
              do_fail = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      REQ_EVENT: begin
        st_nxt.last_event = now;
        st_nxt.event_seq  = st.event_seq + TimeW'(1);
      end
      REQ_DONE: begin
        if (st.phase == PH_PROBE) begin
          st_nxt.last_event = now;
          if (item.probe_status == 8'd0) begin
            inc[C_OK]          = 1'b1;
            st_nxt.phase       = PH_IDLE;
            st_nxt.phase_start = now;
          end else begin
            inc[C_FAILED]    = 1'b1;
            st_nxt.probe_nak = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_off) begin
      st_nxt.probe_nak   = 1'b0;
      inc[C_TRIES]       = 1'b1;
      st_nxt.phase       = PH_OFF;
      st_nxt.phase_start = now;
      action             = ACT_POWER_OFF;
    end
    if (do_fail) begin
      st_nxt.phase       = PH_FAILED;
      st_nxt.phase_start = now;
      if (!st.reboot_req) begin
        st_nxt.reboot_req = 1'b1;
        action            = ACT_REBOOT;
      end
    end

    for (int i = 0; i < NumCnt; i++) begin
      st_nxt.cnt[i] = st.cnt[i] + {{(TimeW-1){1'b0}}, inc[i]};
    end
  end

endmodule

>>> rtl/core/radio_controller_health_watchdog.sv
// An accepted item is held in the input register, and its result is then written to the result
// register; a result that is not taken holds the next item in the input register.
// Throughput: one item per cycle while the result register is empty or being taken; the whole
// phase update is a single pass of logic between the input register and the result register.
// Reset (synchronous, active low) returns to idle at time zero with all counters
// cleared and all timing registers at their default values.
module radio_controller_health_watchdog
  import rchw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [TimeW-1:0] cfg_wdata
);

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  state_t    st_r;
  state_t    st_nxt;
  cfg_t      cfg_r;
  action_e   action;
  logic      out_valid_r;
  out_item_t out_r;
  out_item_t out_nxt;
  logic      adv;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  rchw_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .action (action)
  );

  always_comb begin
    out_nxt.action               = action;
    out_nxt.phase_now            = st_nxt.phase;
    out_nxt.count_probes_sent    = st_nxt.cnt[C_SENT];
    out_nxt.count_probes_ok      = st_nxt.cnt[C_OK];
    out_nxt.count_probes_failed  = st_nxt.cnt[C_FAILED];
    out_nxt.count_probe_timeouts = st_nxt.cnt[C_TIMEOUTS];
    out_nxt.count_recovery_tries = st_nxt.cnt[C_TRIES];
    out_nxt.count_recovery_done  = st_nxt.cnt[C_DONE];
    out_nxt.count_suppressions   = st_nxt.cnt[C_SUPPRESS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.security_suppress_max_ms <= RstSuppressMax;
      cfg_r.quiet_before_probe_ms    <= RstQuiet;
      cfg_r.no_handle_grace_ms       <= RstNoHandle;
      cfg_r.probe_timeout_ms         <= RstProbeTo;
      cfg_r.power_off_timeout_ms     <= RstOffTo;
      cfg_r.power_on_delay_ms        <= RstOnDelay;
      cfg_r.power_on_timeout_ms      <= RstOnTo;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SUPPRESS_MAX: cfg_r.security_suppress_max_ms <= cfg_wdata;
        REG_QUIET:        cfg_r.quiet_before_probe_ms    <= cfg_wdata;
        REG_NO_HANDLE:    cfg_r.no_handle_grace_ms       <= cfg_wdata;
        REG_PROBE_TO:     cfg_r.probe_timeout_ms         <= cfg_wdata;
        REG_OFF_TO:       cfg_r.power_off_timeout_ms     <= cfg_wdata;
        REG_ON_DELAY:     cfg_r.power_on_delay_ms        <= cfg_wdata;
        REG_ON_TO:        cfg_r.power_on_timeout_ms      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef NO_ASSERTIONS
  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_FAILED |=> st_r.phase == PH_FAILED)
    else $error("failed phase was left without reset");

  a_reboot_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.action == ACT_REBOOT |-> st_r.reboot_req)
    else $error("reboot result without reboot flag");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full output stage");

  a_phase_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(adv) && $past(rst_n) |-> out_r.phase_now == st_r.phase)
    else $error("result phase differs from stored phase");
`endif

endmodule

>>> tb/tb_radio_controller_health_watchdog.sv
`timescale 1ns / 1ps

module tb_radio_controller_health_watchdog;
  import rchw_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 6;
  localparam int LongHold = 200;

  localparam logic [1:0] ReqUnused = 2'd3;

  // Flag order: ctrl_working, claimed_link, security_active, handle_available, hci_is_off.
  localparam logic [4:0] FlagsUp       = 5'b11010;
  localparam logic [4:0] FlagsOff      = 5'b11011;
  localparam logic [4:0] FlagsSec      = 5'b11110;
  localparam logic [4:0] FlagsNoHandle = 5'b11000;
  localparam logic [4:0] FlagsLinkOnly = 5'b01000;
  localparam logic [4:0] FlagsWorkOnly = 5'b10000;
  localparam logic [4:0] FlagsAll      = 5'b11111;
  localparam logic [4:0] FlagsClear    = 5'b00000;

  typedef struct {
    in_item_t it;
    bit       typed;
    action_e  act;
    phase_e   ph;
  } step_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [TimeW-1:0] cfg_wdata;

  radio_controller_health_watchdog dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  phase_e           wd_phase = PH_IDLE;
  logic [TimeW-1:0] phase_since = '0;
  logic [TimeW-1:0] last_event_ms = '0;
  logic [TimeW-1:0] event_seq = '0;
  logic [TimeW-1:0] probe_seq_snap = '0;
  logic [TimeW-1:0] suppress_since = '0;
  logic [TimeW-1:0] no_handle_since = '0;
  bit               nh_wait_armed = 1'b0;
  bit               suppress_armed = 1'b0;
  bit               probe_nak = 1'b0;
  bit               reboot_sent = 1'b0;
  logic [TimeW-1:0] stat_cnt [NumCnt];
  logic [TimeW-1:0] span [7];

  out_item_t        status_reports_due [$];
  step_row_t        directed_steps [$];
  logic [TimeW-1:0] clock_ms = '0;
  int               send_idle_pct = 18;
  int               recv_idle_pct = 75;
  int               mismatch_cnt = 0;
  int               cycle_cnt = 0;
  logic             hold_armed;
  bit               hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit elapsed(logic [TimeW-1:0] now, logic [TimeW-1:0] since,
                                 logic [TimeW-1:0] interval);
    logic [TimeW-1:0] diff;
    diff = now - since;
    return diff >= interval;
  endfunction

  function automatic action_e start_power_cycle(logic [TimeW-1:0] now);
    probe_nak = 1'b0;
    stat_cnt[C_TRIES]++;
    wd_phase = PH_OFF;
    phase_since = now;
    return ACT_POWER_OFF;
  endfunction

  function automatic action_e enter_failed(logic [TimeW-1:0] now);
    wd_phase = PH_FAILED;
    phase_since = now;
    if (reboot_sent) return ACT_NONE;
    reboot_sent = 1'b1;
    return ACT_REBOOT;
  endfunction

  function automatic out_item_t next_status_report(in_item_t it);
    out_item_t        rep;
    action_e          act;
    logic [TimeW-1:0] now;
    bit               held;
    act = ACT_NONE;
    now = it.now_ms;
    case (it.req_type)
      REQ_TICK: begin
        case (wd_phase)
          PH_IDLE: begin
            if (!it.ctrl_working || !it.claimed_link) begin
              nh_wait_armed = 1'b0;
              suppress_armed = 1'b0;
            end else begin
              held = 1'b0;
              if (it.security_active) begin
                if (!suppress_armed) begin
                  suppress_armed = 1'b1;
                  suppress_since = now;
                  stat_cnt[C_SUPPRESS]++;
                end
                held = !elapsed(now, suppress_since, span[REG_SUPPRESS_MAX]);
              end else begin
                suppress_armed = 1'b0;
              end
              if (!held) held = !elapsed(now, last_event_ms, span[REG_QUIET]);
              if (held) begin
                nh_wait_armed = 1'b0;
              end else if (!it.handle_available) begin
                if (!nh_wait_armed) begin
                  nh_wait_armed = 1'b1;
                  no_handle_since = now;
                end else if (elapsed(now, no_handle_since, span[REG_NO_HANDLE])) begin
                  act = start_power_cycle(now);
                end
              end else begin
                nh_wait_armed = 1'b0;
                wd_phase = PH_PROBE;
                phase_since = now;
                probe_seq_snap = event_seq;
                stat_cnt[C_SENT]++;
                act = ACT_PROBE;
              end
            end
          end
          PH_PROBE: begin
            if (probe_nak) begin
              act = start_power_cycle(now);
            end else if (event_seq != probe_seq_snap) begin
              stat_cnt[C_OK]++;
              wd_phase = PH_IDLE;
              phase_since = now;
            end else if (elapsed(now, phase_since, span[REG_PROBE_TO])) begin
              stat_cnt[C_TIMEOUTS]++;
              act = start_power_cycle(now);
            end
          end
          PH_OFF: begin
            if (it.hci_is_off) begin
              wd_phase = PH_WAIT_ON;
              phase_since = now;
            end else if (elapsed(now, phase_since, span[REG_OFF_TO])) begin
              act = enter_failed(now);
            end
          end
          PH_WAIT_ON: begin
            if (elapsed(now, phase_since, span[REG_ON_DELAY])) begin
              wd_phase = PH_ON;
              phase_since = now;
              act = ACT_POWER_ON;
            end
          end
          PH_ON: begin
            if (it.ctrl_working) begin
              wd_phase = PH_IDLE;
              phase_since = now;
              last_event_ms = now;
              stat_cnt[C_DONE]++;
            end else if (elapsed(now, phase_since, span[REG_ON_TO])) begin
              act = enter_failed(now);
            end
          end
          default: begin
          end
        endcase
      end
      REQ_EVENT: begin
        last_event_ms = now;
        event_seq++;
      end
      REQ_DONE: begin
        if (wd_phase == PH_PROBE) begin
          last_event_ms = now;
          if (it.probe_status == 8'd0) begin
            stat_cnt[C_OK]++;
            wd_phase = PH_IDLE;
            phase_since = now;
          end else begin
            stat_cnt[C_FAILED]++;
            probe_nak = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    rep.action = act;
    rep.phase_now = wd_phase;
    rep.count_probes_sent = stat_cnt[C_SENT];
    rep.count_probes_ok = stat_cnt[C_OK];
    rep.count_probes_failed = stat_cnt[C_FAILED];
    rep.count_probe_timeouts = stat_cnt[C_TIMEOUTS];
    rep.count_recovery_tries = stat_cnt[C_TRIES];
    rep.count_recovery_done = stat_cnt[C_DONE];
    rep.count_suppressions = stat_cnt[C_SUPPRESS];
    return rep;
  endfunction

  function automatic step_row_t directed_row(logic [1:0] kind, logic [TimeW-1:0] now,
                                             logic [7:0] status, logic [4:0] flags,
                                             bit typed, action_e act, phase_e ph);
    step_row_t row;
    row.it.req_type = kind;
    row.it.now_ms = now;
    row.it.probe_status = status;
    {row.it.ctrl_working, row.it.claimed_link, row.it.security_active,
     row.it.handle_available, row.it.hci_is_off} = flags;
    row.typed = typed;
    row.act = act;
    row.ph = ph;
    return row;
  endfunction

  // With the guard on, ticks never let a power timeout expire, so the failed
  // phase stays out of reach until the closing segment.
  function automatic in_item_t make_item(int step_max, bit guard);
    in_item_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) clock_ms = clock_ms + $urandom_range(0, step_max);
    else if (pick < 78) clock_ms = clock_ms - 1;
    else if (pick < 88) clock_ms = $urandom;
    it.now_ms = clock_ms;
    pick = $urandom_range(0, 99);
    if (!guard) it.req_type = (pick < 90) ? REQ_TICK : REQ_EVENT;
    else if (wd_phase == PH_PROBE)
      it.req_type = (pick < 40) ? REQ_TICK : (pick < 70) ? REQ_DONE :
                    (pick < 95) ? REQ_EVENT : ReqUnused;
    else
      it.req_type = (pick < 75) ? REQ_TICK : (pick < 90) ? REQ_EVENT :
                    (pick < 97) ? REQ_DONE : ReqUnused;
    it.probe_status = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    it.ctrl_working = guard ? ($urandom_range(0, 99) < 90) : 1'b1;
    it.claimed_link = guard ? ($urandom_range(0, 99) < 90) : 1'b1;
    it.security_active = guard ? ($urandom_range(0, 99) < 25) : 1'b0;
    it.handle_available = guard ? ($urandom_range(0, 99) < 80) : 1'b1;
    it.hci_is_off = guard ? ($urandom_range(0, 1) == 1) : 1'b0;
    if (guard && it.req_type == REQ_TICK) begin
      if (wd_phase == PH_OFF && !it.hci_is_off &&
          elapsed(it.now_ms, phase_since, span[REG_OFF_TO]))
        it.hci_is_off = 1'b1;
      if (wd_phase == PH_ON && !it.ctrl_working &&
          elapsed(it.now_ms, phase_since, span[REG_ON_TO]))
        it.ctrl_working = 1'b1;
    end
    return it;
  endfunction

  task automatic offer_item(input in_item_t it, input bit typed, input action_e act,
                            input phase_e ph);
    out_item_t want;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    want = next_status_report(it);
    if (typed) begin
      want.action = act;
      want.phase_now = ph;
    end
    status_reports_due.push_back(want);
  endtask

  task automatic run_random(input int count, input int step_max, input bit guard);
    repeat (count) offer_item(make_item(step_max, guard), 1'b0, ACT_NONE, PH_IDLE);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (status_reports_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [TimeW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    span[idx] = val;
    @(posedge clk);
  endtask

  task automatic load_spans(input logic [TimeW-1:0] sup, quiet, grace, probe_to,
                            off_to, on_dly, on_to);
    write_reg(REG_SUPPRESS_MAX, sup);
    write_reg(REG_QUIET, quiet);
    write_reg(REG_NO_HANDLE, grace);
    write_reg(REG_PROBE_TO, probe_to);
    write_reg(REG_OFF_TO, off_to);
    write_reg(REG_ON_DELAY, on_dly);
    write_reg(REG_ON_TO, on_to);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [TimeW-1:0] want,
                             input logic [TimeW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin : check_reports
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_reports_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got action %0d phase %0d",
                 $time, out_item.action, out_item.phase_now);
        mismatch_cnt++;
      end else begin
        want = status_reports_due.pop_front();
        check_field("action", want.action, out_item.action);
        check_field("phase_now", want.phase_now, out_item.phase_now);
        check_field("count_probes_sent", want.count_probes_sent,
                    out_item.count_probes_sent);
        check_field("count_probes_ok", want.count_probes_ok, out_item.count_probes_ok);
        check_field("count_probes_failed", want.count_probes_failed,
                    out_item.count_probes_failed);
        check_field("count_probe_timeouts", want.count_probe_timeouts,
                    out_item.count_probe_timeouts);
        check_field("count_recovery_tries", want.count_recovery_tries,
                    out_item.count_recovery_tries);
        check_field("count_recovery_done", want.count_recovery_done,
                    out_item.count_recovery_done);
        check_field("count_suppressions", want.count_suppressions,
                    out_item.count_suppressions);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    step_row_t row;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SUPPRESS_MAX;
    cfg_wdata = '0;
    hold_armed = 1'b0;
    foreach (stat_cnt[i]) stat_cnt[i] = '0;
    span[REG_SUPPRESS_MAX] = RstSuppressMax;
    span[REG_QUIET] = RstQuiet;
    span[REG_NO_HANDLE] = RstNoHandle;
    span[REG_PROBE_TO] = RstProbeTo;
    span[REG_OFF_TO] = RstOffTo;
    span[REG_ON_DELAY] = RstOnDelay;
    span[REG_ON_TO] = RstOnTo;

    directed_steps.push_back(directed_row(REQ_TICK, 0, 8'h00, FlagsUp, 1, ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(ReqUnused, 32'hFFFF_FFFF, 8'hFF, FlagsAll, 1,
                                          ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_DONE, 100, 8'h00, FlagsUp, 1, ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 2000, 8'h00, FlagsUp, 1,
                                          ACT_PROBE, PH_PROBE));
    directed_steps.push_back(directed_row(REQ_EVENT, 2100, 8'h00, FlagsClear, 0,
                                          ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 2200, 8'h00, FlagsUp, 1, ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 4100, 8'h00, FlagsUp, 0, ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_DONE, 4200, 8'h00, FlagsUp, 1, ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 6200, 8'h00, FlagsUp, 0, ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_DONE, 6300, 8'hFF, FlagsUp, 1,
                                          ACT_NONE, PH_PROBE));
    directed_steps.push_back(directed_row(REQ_TICK, 6301, 8'h00, FlagsUp, 1,
                                          ACT_POWER_OFF, PH_OFF));
    directed_steps.push_back(directed_row(REQ_TICK, 6400, 8'h00, FlagsOff, 0,
                                          ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 6900, 8'h00, FlagsUp, 1,
                                          ACT_POWER_ON, PH_ON));
    directed_steps.push_back(directed_row(REQ_TICK, 7000, 8'h00, FlagsUp, 0, ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 8000, 8'h00, FlagsSec, 0, ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 38000, 8'h00, FlagsSec, 0,
                                          ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 39000, 8'h00, FlagsUp, 1,
                                          ACT_POWER_OFF, PH_OFF));
    directed_steps.push_back(directed_row(REQ_TICK, 39100, 8'h00, FlagsOff, 0,
                                          ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 39599, 8'h00, FlagsUp, 0,
                                          ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 39600, 8'h00, FlagsUp, 0,
                                          ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 39700, 8'h00, FlagsLinkOnly, 0,
                                          ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 39800, 8'h00, FlagsWorkOnly, 0,
                                          ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 41800, 8'h00, FlagsNoHandle, 0,
                                          ACT_NONE, PH_IDLE));
    directed_steps.push_back(directed_row(REQ_TICK, 44800, 8'h00, FlagsNoHandle, 1,
                                          ACT_POWER_OFF, PH_OFF));
    directed_steps.push_back(directed_row(REQ_TICK, 44900, 8'h00, FlagsOff, 0,
                                          ACT_NONE, PH_IDLE));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      offer_item(row.it, row.typed, row.act, row.ph);
    end

    // Short intervals and a start just below the wrap point of the time base.
    wait_quiet();
    load_spans(40, 20, 30, 25, 30, 10, 40);
    clock_ms = 32'hFFFF_FF00;
    run_random(350, 60, 1'b1);

    wait_quiet();
    send_idle_pct = 75;
    recv_idle_pct = 18;
    load_spans(0, 0, 0, 0, 0, 0, 0);
    run_random(150, 5, 1'b1);

    wait_quiet();
    load_spans('1, '1, '1, '1, '1, '1, '1);
    run_random(100, 1000, 1'b1);

    wait_quiet();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_spans($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 200),
               $urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 200),
               $urandom_range(0, 200));
    hold_armed <= 1'b1;
    run_random(300, 150, 1'b1);

    wait_quiet();
    load_spans(300, 200, 300, 100, 200, 50, 500);
    run_random(100, 400, 1'b1);

    // With every interval at zero, healthy-looking ticks walk the block into
    // the terminal failed phase, where it must stay quiet.
    wait_quiet();
    load_spans(0, 0, 0, 0, 0, 0, 0);
    run_random(40, 10, 1'b0);

    wait_quiet();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rchw_pkg.sv
rtl/core/rchw_step.sv
rtl/core/radio_controller_health_watchdog.sv
tb/tb_radio_controller_health_watchdog.sv
